FILE: hdl/assert_macros.svh
// Assertion macros shared by the torus reach-mask RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/tdmr_pkg.sv
// Shared types and constants for the torus reach-mask block.
// No dependencies; imported by every module of the block.
package tdmr_pkg;

  localparam int COORD_W = 6;
  localparam int SIZE_W  = 7;
  localparam int MASK_W  = 64;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  // One node of the coordinate table.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } node_row_t;

  // Table sweep status toward the datapath.
  typedef struct packed {
    logic busy;
    logic too_many;
  } tbl_status_t;

  // Packed so that mask_x_plus lands in the lowest bits.
  typedef struct packed {
    logic [MASK_W-1:0] mask_local;
    logic [MASK_W-1:0] mask_z_minus;
    logic [MASK_W-1:0] mask_z_plus;
    logic [MASK_W-1:0] mask_y_minus;
    logic [MASK_W-1:0] mask_y_plus;
    logic [MASK_W-1:0] mask_x_minus;
    logic [MASK_W-1:0] mask_x_plus;
  } port_masks_t;

endpackage

FILE: hdl/tdmr_node_table.sv
// Coordinate table: one row per bit position, filled by a sweep of the node counter.
// Depends on tdmr_pkg.
module tdmr_node_table import tdmr_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           restart,
  input  logic [SIZE_W-1:0]              size_x,
  input  logic [SIZE_W-1:0]              size_y,
  input  logic [SIZE_W-1:0]              size_z,
  output node_row_t [MAX_NODES-1:0]      rows,
  output tbl_status_t                    status
);

  localparam int CNT_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     too_many_r, too_many_nxt;
  logic [SIZE_W-1:0]        x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [SIZE_W-1:0]        x_inc, y_inc;
  logic                     last;
  node_row_t                row_wr;
  node_row_t [MAX_NODES-1:0] rows_r;

  assign x_inc = x_r + SIZE_W'(1);
  assign y_inc = y_r + SIZE_W'(1);
  assign last  = (cnt_r == CNT_W'(MAX_NODES - 1));

  assign row_wr.valid = (z_r < size_z);
  assign row_wr.x     = x_r[COORD_W-1:0];
  assign row_wr.y     = y_r[COORD_W-1:0];
  assign row_wr.z     = z_r[COORD_W-1:0];

  always_comb begin
    cnt_nxt      = cnt_r;
    busy_nxt     = busy_r;
    too_many_nxt = too_many_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    if (restart) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      x_nxt    = '0;
      y_nxt    = '0;
      z_nxt    = '0;
    end else if (busy_r) begin
      // step the node counter in x, y, z order
      if (x_inc >= size_x) begin
        x_nxt = '0;
        if (y_inc >= size_y) begin
          y_nxt = '0;
          z_nxt = z_r + SIZE_W'(1);
        end else begin
          y_nxt = y_inc;
        end
      end else begin
        x_nxt = x_inc;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        // a node beyond the last row still exists: too many nodes
        too_many_nxt = (z_nxt < size_z);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      busy_r     <= 1'b1;
      too_many_r <= 1'b0;
      x_r        <= '0;
      y_r        <= '0;
      z_r        <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      busy_r     <= busy_nxt;
      too_many_r <= too_many_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      z_r        <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < MAX_NODES; r++) begin
      if (busy_r && !restart && (cnt_r == CNT_W'(r))) begin
        rows_r[r] <= row_wr;
      end
    end
  end

  assign rows            = rows_r;
  assign status.busy     = busy_r;
  assign status.too_many = too_many_r;

endmodule

FILE: hdl/tdmr_mask_calc.sv
// Per-node port classification: one lane per mask bit, all lanes in parallel.
// Depends on tdmr_pkg.
module tdmr_mask_calc import tdmr_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  node_row_t [MAX_NODES-1:0] rows,
  input  logic [COORD_W-1:0]        pos_x,
  input  logic [COORD_W-1:0]        pos_y,
  input  logic [COORD_W-1:0]        pos_z,
  input  logic [SIZE_W-1:0]         size_x,
  input  logic [SIZE_W-1:0]         size_y,
  input  logic [SIZE_W-1:0]         size_z,
  input  logic                      err,
  output port_masks_t               masks
);

  logic [MASK_W-1:0] xp, xm, yp, ym, zp, zm, lc;
  logic [SIZE_W-1:0] px, py, pz, hx, hy, hz;

  assign px = {1'b0, pos_x};
  assign py = {1'b0, pos_y};
  assign pz = {1'b0, pos_z};
  assign hx = size_x >> 1;
  assign hy = size_y >> 1;
  assign hz = size_z >> 1;

  for (genvar i = 0; i < MASK_W; i++) begin : g_lane
    if (i < MAX_NODES) begin : g_node
      logic [SIZE_W-1:0] rx, ry, rz, dx, dy, dz;
      logic              ne_x, ne_y, ne_z, hit;

      assign rx = {1'b0, rows[i].x};
      assign ry = {1'b0, rows[i].y};
      assign rz = {1'b0, rows[i].z};
      // forward distance, wrapped into [0, size)
      assign dx = (rx >= px) ? (rx - px) : (rx - px + size_x);
      assign dy = (ry >= py) ? (ry - py) : (ry - py + size_y);
      assign dz = (rz >= pz) ? (rz - pz) : (rz - pz + size_z);
      assign ne_x = (rx != px);
      assign ne_y = (ry != py);
      assign ne_z = (rz != pz);
      assign hit  = rows[i].valid && !err;

      assign xp[i] = hit && ne_x && (dx <= hx);
      assign xm[i] = hit && ne_x && (dx > hx);
      assign yp[i] = hit && !ne_x && ne_y && (dy <= hy);
      assign ym[i] = hit && !ne_x && ne_y && (dy > hy);
      assign zp[i] = hit && !ne_x && !ne_y && ne_z && (dz <= hz);
      assign zm[i] = hit && !ne_x && !ne_y && ne_z && (dz > hz);
      assign lc[i] = hit && !ne_x && !ne_y && !ne_z;
    end else begin : g_none
      assign xp[i] = 1'b0;
      assign xm[i] = 1'b0;
      assign yp[i] = 1'b0;
      assign ym[i] = 1'b0;
      assign zp[i] = 1'b0;
      assign zm[i] = 1'b0;
      assign lc[i] = 1'b0;
    end
  end

  assign masks = '{mask_local: lc, mask_z_minus: zm, mask_z_plus: zp,
                   mask_y_minus: ym, mask_y_plus: yp,
                   mask_x_minus: xm, mask_x_plus: xp};

endmodule

FILE: hdl/torus_dor_port_reach_masks_top.sv
// An item passes the input register and then the result register; out_tvalid is the latter's valid.
// Throughput: one item per cycle unless out_tready is low or a sweep runs; the mask logic is a
// single pass of 64 parallel lanes. After reset and after every configuration write, the
// coordinate table is refilled by a sweep while in_tready stays low.
// Reset is synchronous, active low; it restores all sizes to 4 and empties the pipeline.
// Depends on tdmr_pkg, tdmr_node_table, tdmr_mask_calc and assert_macros.svh.
`include "assert_macros.svh"

module torus_dor_port_reach_masks_top import tdmr_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // pos_x[5:0], pos_y[11:6], pos_z[17:12], zero pad
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7*MASK_W-1:0]   out_tdata,  // mask_x_plus, mask_x_minus, mask_y_plus,
                                            // mask_y_minus, mask_z_plus, mask_z_minus,
                                            // mask_local, 64 bits each from bit 0 up
  output logic                  out_tuser   // size_error
);

  // configuration registers
  logic [SIZE_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic [SIZE_W-1:0]  size_x_nxt, size_y_nxt, size_z_nxt;
  logic               cfg_fire;

  // input stage
  logic               s1_valid_r, s1_valid_nxt;
  logic [COORD_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic               in_fire, advance, s1_free;

  // result stage
  logic               out_valid_r, out_valid_nxt;
  port_masks_t        masks_r, masks_calc;
  logic               err_r, err_calc;

  node_row_t [MAX_NODES-1:0] rows;
  tbl_status_t               tbl_status;

  // Configuration: always ready; any write restarts the table sweep.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    size_x_nxt = size_x_r;
    size_y_nxt = size_y_r;
    size_z_nxt = size_z_r;
    if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: size_x_nxt = cfg_data;
        REG_SIZE_Y: size_y_nxt = cfg_data;
        REG_SIZE_Z: size_z_nxt = cfg_data;
        default:    ;  // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_W'(4);
      size_y_r <= SIZE_W'(4);
      size_z_r <= SIZE_W'(4);
    end else begin
      size_x_r <= size_x_nxt;
      size_y_r <= size_y_nxt;
      size_z_r <= size_z_nxt;
    end
  end

  tdmr_node_table #(
    .MAX_NODES (MAX_NODES)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_fire),
    .size_x  (size_x_r),
    .size_y  (size_y_r),
    .size_z  (size_z_r),
    .rows    (rows),
    .status  (tbl_status)
  );

  // Pipeline control: the result register moves when empty or taken; the
  // input register refills whenever it empties into the result register.
  assign advance   = !out_valid_r || out_tready;
  assign s1_free   = !s1_valid_r || advance;
  assign in_tready = s1_free && !tbl_status.busy;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the position of the item under work.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_x_r <= in_tdata[5:0];
      pos_y_r <= in_tdata[11:6];
      pos_z_r <= in_tdata[17:12];
    end
  end

  // Error: too many nodes, or position outside the configured torus.
  assign err_calc = tbl_status.too_many ||
                    ({1'b0, pos_x_r} >= size_x_r) ||
                    ({1'b0, pos_y_r} >= size_y_r) ||
                    ({1'b0, pos_z_r} >= size_z_r);

  tdmr_mask_calc #(
    .MAX_NODES (MAX_NODES)
  ) u_calc (
    .rows   (rows),
    .pos_x  (pos_x_r),
    .pos_y  (pos_y_r),
    .pos_z  (pos_z_r),
    .size_x (size_x_r),
    .size_y (size_y_r),
    .size_z (size_z_r),
    .err    (err_calc),
    .masks  (masks_calc)
  );

  // Capture the result when it advances out of the input stage.
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      masks_r <= masks_calc;
      err_r   <= err_calc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = masks_r;
  assign out_tuser  = err_r;

  // Assertions
  `ASSERT_CLK(a_no_accept_in_sweep, tbl_status.busy |-> !in_tready,
              "item accepted during table sweep")
  `ASSERT_CLK(a_cfg_starts_sweep, cfg_fire |=> tbl_status.busy,
              "config write did not restart sweep")
  `ASSERT_CLK(a_err_zero_masks, (out_valid_r && err_r) |-> (masks_r == '0),
              "error result has masks set")
  `ASSERT_CLK(a_local_onehot, (out_valid_r && !err_r) |-> $onehot(masks_r.mask_local),
              "local mask not one bit")
  `ASSERT_CLK(a_x_disjoint,
              out_valid_r |-> ((masks_r.mask_x_plus & masks_r.mask_x_minus) == '0),
              "x masks overlap")
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_r && !s1_valid_r),
                 "pipeline not empty after reset")

endmodule
